// ----- rtl/hdu_pkg.sv -----
// Shared types and constants for the half-duplex UART with queues.
// No dependencies; imported by hdu_line_ctrl and the top level.
package hdu_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PHASE_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SAMPLE = 1'd1;

  localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RESET   = 16'd833;
  localparam logic [CFG_DATA_W-1:0] FIRST_SAMPLE_RESET = 16'd416;

  // Queue status seen by the line controller, already ordered as
  // read, then write, then line activity.
  typedef struct packed {
    logic rx_pop_ok;  // host read pops a byte this cycle
    logic rx_room;    // receive queue can take a byte after the pop
    logic tx_has;     // transmit queue non-empty after the host write
    logic tx_more;    // still non-empty after the write and one pop
  } hdu_queue_stat_t;

  // Queue operations requested by the line controller
  typedef struct packed {
    logic rx_push;
    logic tx_pop;
  } hdu_queue_op_t;

  // Line-side status of the controller
  typedef struct packed {
    logic               tx_level;
    logic               tx_enable;
    logic               overflow;
    logic [PHASE_W-1:0] phase;
  } hdu_line_out_t;

endpackage

// ----- rtl/hdu_fifo.sv -----
// Byte queue with circular pointers and a registered front-entry read.
// Uses no package items; instantiated twice by the top level.
module hdu_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [7:0]                 push_data,
  input  logic                       pop,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [7:0]                 front
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [CW-1:0] count_next;
  logic          pop_ok;
  logic          push_ok;

  always_comb begin
    pop_ok  = pop && (count != '0);
    // a full queue still takes a byte when a pop frees a slot in the same cycle
    push_ok = push && ((count != CW'(DEPTH)) || pop_ok);

    tail_next = tail;
    if (pop_ok) begin
      tail_next = (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
    end
    head_next = head;
    if (push_ok) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
    end

    count_next = count;
    if (push_ok && !pop_ok) begin
      count_next = count + CW'(1);
    end else if (pop_ok && !push_ok) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Storage and front read; bypass a write that lands on the new front entry
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[head] <= push_data;
    end
    if (push_ok && (head == tail_next)) begin
      front <= push_data;
    end else begin
      front <= mem[tail_next];
    end
  end

endmodule

// ----- rtl/hdu_line_ctrl.sv -----
// Line sequencer: reception, transmit framing, abort and retry, overflow.
// Depends on hdu_pkg for the queue and status structs.
module hdu_line_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        level,
  input  logic [15:0]                 bit_period,
  input  logic [15:0]                 first_sample_delay,
  input  hdu_pkg::hdu_queue_stat_t    stat,
  input  logic [7:0]                  tx_front,
  output hdu_pkg::hdu_queue_op_t      ops,
  output logic [7:0]                  rx_byte,
  output hdu_pkg::hdu_line_out_t      line
);
  import hdu_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_DATA  = 3'd2,
    PH_STOP  = 3'd3,
    PH_GAP   = 3'd4,
    PH_TX1   = 3'd5,
    PH_TX2   = 3'd6
  } phase_t;

  localparam logic [3:0] SLOT_START     = 4'd1;
  localparam logic [3:0] SLOT_DATA0     = 4'd2;
  localparam logic [3:0] SLOT_STOP      = 4'd10;
  localparam logic [3:0] FRAME_SLOTS    = 4'd11;
  localparam logic [3:0] TX1_SLOTS      = 4'd7;
  localparam logic [3:0] GAP_SLOTS      = 4'd2;
  localparam logic [3:0] RX_DATA_BITS   = 4'd8;

  phase_t      phase, phase_next;
  logic [15:0] tick, tick_next, tick_inc;
  logic [3:0]  bit_idx, bit_idx_next, bit_inc, data_sel;
  logic [7:0]  rx_shift, rx_shift_next;
  logic        prev_line, prev_line_next;
  logic        aborted, aborted_next;
  logic        overflow, overflow_next;
  logic        edge_fall;
  logic        slot_hit;

  always_comb begin
    phase_next     = phase;
    tick_next      = tick;
    bit_idx_next   = bit_idx;
    rx_shift_next  = rx_shift;
    prev_line_next = prev_line;
    aborted_next   = aborted;
    overflow_next  = overflow;
    ops            = '0;

    tick_inc  = tick + 16'd1;
    bit_inc   = bit_idx + 4'd1;
    slot_hit  = (tick_inc >= bit_period);
    edge_fall = prev_line && !level;

    if (step) begin
      prev_line_next = level;
      if (stat.rx_pop_ok) begin
        overflow_next = 1'b0;
      end

      case (phase)
        PH_IDLE: begin
          if (edge_fall) begin
            phase_next   = PH_START;
            tick_next    = '0;
            bit_idx_next = '0;
          end else if (stat.tx_has) begin
            phase_next   = PH_TX1;
            tick_next    = '0;
            bit_idx_next = '0;
          end
        end
        PH_GAP, PH_TX1, PH_TX2: begin
          if (edge_fall) begin
            if ((phase == PH_TX2) && (bit_idx >= SLOT_STOP)) begin
              ops.tx_pop = 1'b1;  // stop bit already out: byte counts as sent
            end else if ((phase == PH_TX1) && (bit_idx == '0)) begin
              // idle-high slot: release the line, keep the byte queued
            end else if (phase != PH_GAP) begin
              aborted_next = 1'b1;
            end
            phase_next   = PH_START;
            tick_next    = '0;
            bit_idx_next = '0;
          end else if (slot_hit) begin
            tick_next    = '0;
            bit_idx_next = bit_inc;
            if (phase == PH_GAP) begin
              if (bit_inc >= GAP_SLOTS) begin
                phase_next   = stat.tx_has ? PH_TX1 : PH_IDLE;
                bit_idx_next = '0;
              end
            end else if (phase == PH_TX1) begin
              if (bit_inc >= TX1_SLOTS) begin
                phase_next = PH_TX2;
              end
            end else if (bit_inc >= FRAME_SLOTS) begin
              ops.tx_pop   = 1'b1;
              phase_next   = stat.tx_more ? PH_TX1 : PH_IDLE;
              bit_idx_next = '0;
            end
          end else begin
            tick_next = tick_inc;
          end
        end
        PH_START: begin
          if (tick_inc >= first_sample_delay) begin
            tick_next    = '0;
            bit_idx_next = '0;
            phase_next   = PH_DATA;
          end else begin
            tick_next = tick_inc;
          end
        end
        PH_DATA: begin
          if (slot_hit) begin
            tick_next     = '0;
            rx_shift_next = {level, rx_shift[7:1]};
            if (bit_inc >= RX_DATA_BITS) begin
              bit_idx_next = '0;
              phase_next   = PH_STOP;
            end else begin
              bit_idx_next = bit_inc;
            end
          end else begin
            tick_next = tick_inc;
          end
        end
        PH_STOP: begin
          if (slot_hit) begin
            tick_next    = '0;
            bit_idx_next = '0;
            if (level) begin
              if (stat.rx_room) begin
                ops.rx_push = 1'b1;
              end else begin
                overflow_next = 1'b1;
              end
            end
            if (aborted) begin
              aborted_next = 1'b0;
              phase_next   = PH_GAP;
            end else begin
              phase_next = stat.tx_has ? PH_TX1 : PH_IDLE;
            end
          end else begin
            tick_next = tick_inc;
          end
        end
        default: begin
          phase_next   = PH_IDLE;
          tick_next    = '0;
          bit_idx_next = '0;
        end
      endcase
    end
  end

  // Drive level from the stored state
  always_comb begin
    data_sel       = bit_idx - SLOT_DATA0;
    line.overflow  = overflow;
    line.phase     = phase;
    line.tx_enable = 1'b0;
    line.tx_level  = 1'b1;
    case (phase)
      PH_IDLE: begin
        line.tx_enable = 1'b0;
        line.tx_level  = 1'b1;
      end
      PH_START, PH_DATA, PH_STOP: begin
        line.tx_enable = aborted;
        line.tx_level  = !aborted;
      end
      PH_GAP: begin
        line.tx_enable = 1'b1;
        line.tx_level  = (bit_idx != '0);
      end
      PH_TX1, PH_TX2: begin
        line.tx_enable = 1'b1;
        if ((bit_idx == '0) || (bit_idx >= SLOT_STOP)) begin
          line.tx_level = 1'b1;
        end else if (bit_idx == SLOT_START) begin
          line.tx_level = 1'b0;
        end else begin
          line.tx_level = tx_front[data_sel[2:0]];
        end
      end
      default: begin
        line.tx_enable = 1'b0;
        line.tx_level  = 1'b1;
      end
    endcase
  end

  assign rx_byte = rx_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      tick      <= '0;
      bit_idx   <= '0;
      rx_shift  <= '0;
      prev_line <= 1'b1;
      aborted   <= 1'b0;
      overflow  <= 1'b0;
    end else begin
      phase     <= phase_next;
      tick      <= tick_next;
      bit_idx   <= bit_idx_next;
      rx_shift  <= rx_shift_next;
      prev_line <= prev_line_next;
      aborted   <= aborted_next;
      overflow  <= overflow_next;
    end
  end

endmodule

// ----- rtl/half_duplex_uart_with_fifos.sv -----
// Half-duplex 8N1 UART top level: one request per clock unless a finished result is held back, receive priority.
// Latency: the result of a request is registered and shown the next cycle.
// Throughput: one request per cycle; a request is taken while the previous
// result waits, as long as that result is taken in the same cycle.
// Reset (rst, synchronous): queues empty, line idle, registers 833 and 416.
// Depends on hdu_pkg, hdu_fifo and hdu_line_ctrl.
module half_duplex_uart_with_fifos #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                rx_level,
  input  logic                                write_valid,
  input  logic [7:0]                          write_byte,
  input  logic                                read_request,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                tx_level,
  output logic                                tx_enable,
  output logic                                read_valid,
  output logic [7:0]                          read_data,
  output logic [$clog2(RX_DEPTH+1)-1:0]       rx_fill,
  output logic [$clog2(TX_DEPTH+1)-1:0]       tx_fill,
  output logic                                overflow_flag,
  output logic [hdu_pkg::PHASE_W-1:0]         line_phase,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hdu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hdu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hdu_pkg::*;

  localparam int unsigned RCW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TCW = $clog2(TX_DEPTH + 1);

  logic [CFG_DATA_W-1:0] bit_period;
  logic [CFG_DATA_W-1:0] first_sample_delay;

  logic            accept;
  logic            rx_pop_req;
  logic            tx_push_req;
  logic            tx_wr_ok;
  logic [RCW-1:0]  rx_count;
  logic [TCW-1:0]  tx_count;
  logic [7:0]      rx_front;
  logic [7:0]      tx_front;
  logic [7:0]      rx_byte;
  logic [7:0]      read_byte;

  hdu_queue_stat_t stat;
  hdu_queue_op_t   ops;
  hdu_line_out_t   line;

  // Take a new request unless a finished result is still held back.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period         <= BIT_PERIOD_RESET;
      first_sample_delay <= FIRST_SAMPLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIT_PERIOD:   bit_period         <= cfg_data;
        CFG_FIRST_SAMPLE: first_sample_delay <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Host side of the queues: read first, then write, then line activity.
  // A write to a full transmit queue is dropped even if the line pops a byte
  // in the same cycle, since the pop comes after the write.
  assign rx_pop_req  = accept && read_request;
  assign tx_push_req = accept && write_valid;
  assign tx_wr_ok    = tx_push_req && (tx_count != TCW'(TX_DEPTH));

  always_comb begin
    stat.rx_pop_ok = rx_pop_req && (rx_count != '0);
    stat.rx_room   = (rx_count != RCW'(RX_DEPTH)) || stat.rx_pop_ok;
    stat.tx_has    = (tx_count != '0) || tx_wr_ok;
    // after a pop the queue keeps a byte if it held two, counting this write
    stat.tx_more   = (tx_count > TCW'(1)) || ((tx_count == TCW'(1)) && tx_wr_ok);
  end

  hdu_fifo #(
    .DEPTH (RX_DEPTH)
  ) u_rx_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (ops.rx_push),
    .push_data (rx_byte),
    .pop       (rx_pop_req),
    .count     (rx_count),
    .front     (rx_front)
  );

  hdu_fifo #(
    .DEPTH (TX_DEPTH)
  ) u_tx_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (tx_wr_ok),
    .push_data (write_byte),
    .pop       (ops.tx_pop),
    .count     (tx_count),
    .front     (tx_front)
  );

  hdu_line_ctrl u_line_ctrl (
    .clk                (clk),
    .rst                (rst),
    .step               (accept),
    .level              (rx_level),
    .bit_period         (bit_period),
    .first_sample_delay (first_sample_delay),
    .stat               (stat),
    .tx_front           (tx_front),
    .ops                (ops),
    .rx_byte            (rx_byte),
    .line               (line)
  );

  // Result register: valid flag and the popped byte. The other result fields
  // are the state registers themselves, which only move on an accepted request
  // and therefore hold while the result is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      read_valid <= 1'b0;
    end else if (accept) begin
      out_valid  <= 1'b1;
      read_valid <= stat.rx_pop_ok;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the popped byte; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (stat.rx_pop_ok) begin
      read_byte <= rx_front;
    end
  end

  assign read_data     = read_valid ? read_byte : 8'd0;
  assign rx_fill       = rx_count;
  assign tx_fill       = tx_count;
  assign tx_level      = line.tx_level;
  assign tx_enable     = line.tx_enable;
  assign overflow_flag = line.overflow;
  assign line_phase    = line.phase;

endmodule

// ----- tb/hdu_line_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the half-duplex UART: tracks the line, queues and registers per request.
// Depends on hdu_pkg; instantiated beside the block by the testbench top.
module hdu_line_checker #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                rx_level,
  input  logic                                write_valid,
  input  logic [7:0]                          write_byte,
  input  logic                                read_request,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                tx_level,
  input  logic                                tx_enable,
  input  logic                                read_valid,
  input  logic [7:0]                          read_data,
  input  logic [$clog2(RX_DEPTH+1)-1:0]       rx_fill,
  input  logic [$clog2(TX_DEPTH+1)-1:0]       tx_fill,
  input  logic                                overflow_flag,
  input  logic [hdu_pkg::PHASE_W-1:0]         line_phase,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [hdu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hdu_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
  localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);

  typedef enum logic [2:0] {
    LINE_IDLE    = 3'd0,
    LINE_START   = 3'd1,
    LINE_DATA    = 3'd2,
    LINE_STOP    = 3'd3,
    LINE_GAP     = 3'd4,
    LINE_TX_HEAD = 3'd5,
    LINE_TX_TAIL = 3'd6
  } line_phase_e;

  typedef struct packed {
    logic                 tx_level;
    logic                 tx_enable;
    logic                 read_valid;
    logic [7:0]           read_data;
    logic [RX_FILL_W-1:0] rx_fill;
    logic [TX_FILL_W-1:0] tx_fill;
    logic                 overflow;
    line_phase_e          phase;
  } line_result_t;

  logic [7:0]  rx_store [RX_DEPTH];
  logic [7:0]  tx_store [TX_DEPTH];
  int          rx_head, rx_tail, rx_count;
  int          tx_head, tx_tail, tx_count;
  line_phase_e ph;
  int          ticks, slot;
  logic [7:0]  rx_shift;
  logic        aborted, overflow, line_prev;
  logic [15:0] bit_period, first_sample;

  line_result_t line_results_due [$];
  int           errs = 0;

  function automatic void start_receive();
    ph = LINE_START;
    ticks = 0;
    slot = 0;
  endfunction

  function automatic void frame_or_idle();
    ph = (tx_count > 0) ? LINE_TX_HEAD : LINE_IDLE;
    ticks = 0;
    slot = 0;
  endfunction

  function automatic void drop_sent_byte();
    if (tx_count > 0) begin
      tx_tail = (tx_tail + 1) % TX_DEPTH;
      tx_count--;
    end
  endfunction

  function automatic logic slot_elapsed();
    ticks++;
    if (ticks >= bit_period) begin
      ticks = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the line by one request; returns what the block shows afterwards.
  function automatic line_result_t step_line(input logic lvl, input logic wv,
                                             input logic [7:0] wb, input logic rr);
    line_result_t r;
    logic         fell;
    r = '0;
    if (rr && rx_count > 0) begin
      r.read_valid = 1'b1;
      r.read_data  = rx_store[rx_tail];
      rx_tail      = (rx_tail + 1) % RX_DEPTH;
      rx_count--;
      overflow     = 1'b0;
    end
    if (wv && tx_count < TX_DEPTH) begin
      tx_store[tx_head] = wb;
      tx_head = (tx_head + 1) % TX_DEPTH;
      tx_count++;
    end
    fell = line_prev & ~lvl;
    line_prev = lvl;

    case (ph)
      LINE_IDLE: begin
        if (fell) start_receive();
        else if (tx_count > 0) frame_or_idle();
      end
      LINE_GAP, LINE_TX_HEAD, LINE_TX_TAIL: begin
        if (fell) begin
          // stop slot counts as sent; idle-high slot and gap only release the line
          if (ph == LINE_TX_TAIL && slot >= 10) drop_sent_byte();
          else if (!(ph == LINE_TX_HEAD && slot == 0) && ph != LINE_GAP) aborted = 1'b1;
          start_receive();
        end else if (slot_elapsed()) begin
          slot++;
          if (ph == LINE_GAP) begin
            if (slot >= 2) frame_or_idle();
          end else if (ph == LINE_TX_HEAD) begin
            if (slot >= 7) ph = LINE_TX_TAIL;
          end else if (slot >= 11) begin
            drop_sent_byte();
            frame_or_idle();
          end
        end
      end
      LINE_START: begin
        ticks++;
        if (ticks >= first_sample) begin
          ticks = 0;
          slot = 0;
          ph = LINE_DATA;
        end
      end
      LINE_DATA: begin
        if (slot_elapsed()) begin
          rx_shift = {lvl, rx_shift[7:1]};
          slot++;
          if (slot >= 8) begin
            slot = 0;
            ph = LINE_STOP;
          end
        end
      end
      LINE_STOP: begin
        if (slot_elapsed()) begin
          if (lvl) begin
            if (rx_count < RX_DEPTH) begin
              rx_store[rx_head] = rx_shift;
              rx_head = (rx_head + 1) % RX_DEPTH;
              rx_count++;
            end else begin
              overflow = 1'b1;
            end
          end
          if (aborted) begin
            aborted = 1'b0;
            ph = LINE_GAP;
            slot = 0;
            ticks = 0;
          end else begin
            frame_or_idle();
          end
        end
      end
      default: begin
        ph = LINE_IDLE;
        ticks = 0;
        slot = 0;
      end
    endcase

    if (ph == LINE_IDLE) begin
      r.tx_enable = 1'b0;
      r.tx_level  = 1'b1;
    end else if (ph <= LINE_STOP) begin
      r.tx_enable = aborted;
      r.tx_level  = ~aborted;
    end else if (ph == LINE_GAP) begin
      r.tx_enable = 1'b1;
      r.tx_level  = (slot != 0);
    end else begin
      r.tx_enable = 1'b1;
      if (slot == 0 || slot >= 10) r.tx_level = 1'b1;
      else if (slot == 1) r.tx_level = 1'b0;
      else r.tx_level = tx_store[tx_tail][slot-2];
    end
    r.rx_fill  = RX_FILL_W'(rx_count);
    r.tx_fill  = TX_FILL_W'(tx_count);
    r.overflow = overflow;
    r.phase    = ph;
    return r;
  endfunction

  function automatic void check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    line_result_t due;
    if (rst) begin
      for (int i = 0; i < RX_DEPTH; i++) rx_store[i] = 8'h00;
      for (int i = 0; i < TX_DEPTH; i++) tx_store[i] = 8'h00;
      rx_head = 0; rx_tail = 0; rx_count = 0;
      tx_head = 0; tx_tail = 0; tx_count = 0;
      ph = LINE_IDLE;
      ticks = 0; slot = 0; rx_shift = 8'h00;
      aborted = 1'b0; overflow = 1'b0; line_prev = 1'b1;
      bit_period   = hdu_pkg::BIT_PERIOD_RESET;
      first_sample = hdu_pkg::FIRST_SAMPLE_RESET;
      line_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hdu_pkg::CFG_BIT_PERIOD:   bit_period   = cfg_data;
          hdu_pkg::CFG_FIRST_SAMPLE: first_sample = cfg_data;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (line_results_due.size() == 0) begin
          $error("result seen with no request outstanding");
          errs++;
        end else begin
          due = line_results_due.pop_front();
          check_field("tx_level", due.tx_level, tx_level);
          check_field("tx_enable", due.tx_enable, tx_enable);
          check_field("read_valid", due.read_valid, read_valid);
          check_field("read_data", due.read_data, read_data);
          check_field("rx_fill", due.rx_fill, rx_fill);
          check_field("tx_fill", due.tx_fill, tx_fill);
          check_field("overflow_flag", due.overflow, overflow_flag);
          check_field("line_phase", due.phase, line_phase);
        end
      end
      if (in_valid && !in_stall)
        line_results_due.push_back(step_line(rx_level, write_valid, write_byte, read_request));
    end
    fail_count <= errs;
    pending    <= line_results_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the half-duplex UART regression: clock, reset, line and host stimulus, verdict.
// Depends on hdu_pkg, the block and hdu_line_checker.
module testbench;
  import hdu_pkg::*;

  localparam int unsigned RX_DEPTH    = 16;
  localparam int unsigned TX_DEPTH    = 16;
  localparam int          CYCLE_LIMIT = 2_000_000;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic                          rx_level     = 1'b1;
  logic                          write_valid  = 1'b0;
  logic [7:0]                    write_byte   = 8'h00;
  logic                          read_request = 1'b0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic                          tx_level;
  logic                          tx_enable;
  logic                          read_valid;
  logic [7:0]                    read_data;
  logic [$clog2(RX_DEPTH+1)-1:0] rx_fill;
  logic [$clog2(TX_DEPTH+1)-1:0] tx_fill;
  logic                          overflow_flag;
  logic [PHASE_W-1:0]            line_phase;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_W-1:0]        cfg_index    = '0;
  logic [CFG_DATA_W-1:0]         cfg_data     = '0;
  int                            fail_count;
  int                            pending;

  // Stretches with quiet set run with no gaps and start no new stalls.
  logic quiet       = 1'b0;
  int   stall_left  = 0;
  // Bit period the line generator currently assumes.
  int   cur_period  = BIT_PERIOD_RESET;
  // Line levels still to be driven, one per request.
  logic line_q [$];
  int   cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  half_duplex_uart_with_fifos #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_level(rx_level), .write_valid(write_valid), .write_byte(write_byte),
    .read_request(read_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_level(tx_level), .tx_enable(tx_enable), .read_valid(read_valid),
    .read_data(read_data), .rx_fill(rx_fill), .tx_fill(tx_fill),
    .overflow_flag(overflow_flag), .line_phase(line_phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hdu_line_checker #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_level(rx_level), .write_valid(write_valid), .write_byte(write_byte),
    .read_request(read_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_level(tx_level), .tx_enable(tx_enable), .read_valid(read_valid),
    .read_data(read_data), .rx_fill(rx_fill), .tx_fill(tx_fill),
    .overflow_flag(overflow_flag), .line_phase(line_phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Pause length drawn from three ranges: mostly the shortest, sometimes the middle, rarely the longest.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // Result side: stall in random bursts, dropping the stall between them.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_stall && !quiet && $urandom_range(0, 99) < 20) begin
      out_stall  <= 1'b1;
      stall_left <= pause_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hold one request until the block takes it, after an optional gap.
  task automatic put_tick(input logic lvl, input logic wv, input logic [7:0] wb,
                          input logic rr);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 20) ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    rx_level     <= lvl;
    write_valid  <= wv;
    write_byte   <= wb;
    read_request <= rr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write one register with the block drained; restart the line pattern.
  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_results_done();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BIT_PERIOD) cur_period = value;
    line_q.delete();
  endtask

  // Queue the next stretch of line activity: a UART frame, a short glitch or idle high.
  task automatic plan_line(input int frame_pct);
    int         r;
    int         n;
    logic [7:0] data;
    logic       stop_ok;
    r = $urandom_range(0, 99);
    if (r < frame_pct) begin
      data    = $urandom_range(0, 255);
      stop_ok = ($urandom_range(0, 99) >= 6);
      repeat ($urandom_range(0, cur_period / 4)) line_q.push_back(1'b1);
      repeat (cur_period) line_q.push_back(1'b0);
      for (int b = 0; b < 8; b++) repeat (cur_period) line_q.push_back(data[b]);
      repeat (cur_period) line_q.push_back(stop_ok);
      // a framing error leaves the line low; bring it back high before the next start
      if (!stop_ok) repeat (cur_period) line_q.push_back(1'b1);
    end else if (r < frame_pct + (100 - frame_pct) / 2) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(1'b0);
      repeat ($urandom_range(1, 4)) line_q.push_back(1'b1);
    end else begin
      n = 2 * cur_period;
      if (n > 200) n = 200;
      repeat ($urandom_range(1, n)) line_q.push_back(1'b1);
    end
  endtask

  // Random requests: line from the planned pattern, host writes and reads per mille.
  task automatic run_traffic(input int items, input int frame_pct, input int wr_pm,
                             input int rd_pm);
    logic lvl;
    for (int i = 0; i < items; i++) begin
      if (i % 150 == 0) quiet <= ($urandom_range(0, 4) == 0);
      if (line_q.size() == 0) plan_line(frame_pct);
      lvl = line_q.pop_front();
      put_tick(lvl, $urandom_range(0, 999) < wr_pm, 8'($urandom_range(0, 255)),
               $urandom_range(0, 999) < rd_pm);
    end
  endtask

  // Guard against a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("half_duplex_uart_with_fifos regression: fail");
    $finish;
  end

  initial begin
    logic [7:0] corner [8];
    corner = '{8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h0F};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: read of an empty receive queue with the line idle.
    put_tick(1'b1, 1'b0, 8'h00, 1'b1);
    // Start edge and a new byte in the same idle cycle: reception wins.
    put_tick(1'b0, 1'b1, 8'h00, 1'b0);
    // Fill the transmit queue; the last writes land on a full queue and are dropped.
    // Toggle the line meanwhile: edges during reception are ignored.
    for (int i = 0; i < 16; i++)
      put_tick(i[1], 1'b1, (i < 8) ? corner[i] : 8'($urandom_range(0, 255)), i == 15);
    put_tick(1'b1, 1'b1, 8'hC3, 1'b1);

    // Extreme register values, then lower them while counts are under way.
    set_reg(CFG_BIT_PERIOD, 16'hFFFF);
    set_reg(CFG_FIRST_SAMPLE, 16'hFFFF);
    run_traffic(40, 0, 50, 50);
    set_reg(CFG_BIT_PERIOD, 16'd16);
    set_reg(CFG_FIRST_SAMPLE, 16'd8);

    // Mixed traffic at the fastest bit period; hold off the sender once until all is back.
    run_traffic(150, 85, 4, 60);
    wait_results_done();
    run_traffic(150, 85, 4, 60);

    // Sample right after the edge, with heavy host traffic.
    set_reg(CFG_FIRST_SAMPLE, 16'd1);
    run_traffic(150, 70, 100, 100);

    // Park a reception in the start wait, then release it by lowering the delay.
    set_reg(CFG_BIT_PERIOD, 16'd19);
    set_reg(CFG_FIRST_SAMPLE, 16'hFFFF);
    run_traffic(40, 50, 50, 50);
    set_reg(CFG_FIRST_SAMPLE, 16'd9);
    run_traffic(150, 80, 80, 50);

    // Back-to-back frames with no reads: let the receive queue build up.
    set_reg(CFG_BIT_PERIOD, 16'd16);
    set_reg(CFG_FIRST_SAMPLE, 16'd7);
    run_traffic(500, 100, 3, 0);

    // Reset values again; read the queue dry.
    set_reg(CFG_BIT_PERIOD, BIT_PERIOD_RESET);
    set_reg(CFG_FIRST_SAMPLE, FIRST_SAMPLE_RESET);
    run_traffic(100, 0, 30, 600);

    set_reg(CFG_BIT_PERIOD, 16'd17);
    set_reg(CFG_FIRST_SAMPLE, 16'd16);
    run_traffic(150, 60, 10, 200);

    // Drain and let the last result settle before the verdict.
    wait_results_done();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("half_duplex_uart_with_fifos regression: pass");
    else
      $display("half_duplex_uart_with_fifos regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hdu_pkg.sv
rtl/hdu_fifo.sv
rtl/hdu_line_ctrl.sv
rtl/half_duplex_uart_with_fifos.sv
tb/hdu_line_checker.sv
tb/testbench.sv
